>>> hdl/cdsr_pkg.sv
`timescale 1ns / 1ps

package cdsr_pkg;

    localparam int DEFAULT_NUM_CHANNELS = 8;
    localparam int DEFAULT_CAL_STEP     = 256;
    localparam int CAL_ENTRIES          = 256;
    localparam int CAL_INDEX_W          = 8;
    localparam int MAX_RESULTS          = 8;
    localparam int CODE_W               = 16;
    localparam int DAC_CH_W             = 6;
    localparam int IN_DATA_W            = 80;
    localparam int OUT_DATA_W           = 48;
    // Width of the reciprocal used to divide a code by the calibration step.
    localparam int RECIP_W              = 18;

    localparam logic [CODE_W-1:0] CODE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        FUNC_SET        = 3'd0,
        FUNC_GET        = 3'd1,
        FUNC_SET_ALL    = 3'd2,
        FUNC_RAMP_START = 3'd3,
        FUNC_RAMP_NEXT  = 3'd4,
        FUNC_CAL_LOAD   = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_UNKNOWN     = 2'd1,
        STATUS_NOT_RAMPING = 2'd2
    } t_status;

    typedef struct packed {
        logic              ramp_mode;
        logic [CODE_W-1:0] remaining;
        logic [CODE_W-1:0] increment;
        logic [CODE_W-1:0] setpoint;
    } t_chan_state;

endpackage

>>> hdl/calibrated_dac_setpoint_ramp.sv
`timescale 1ns / 1ps

// Multi-channel DAC setpoint controller with per-channel calibration and ramps.
// Requests arrive on the slave stream (i_s_*), one item per request. Results
// leave on the master stream (o_m_*); o_m_tlast marks the final result of a
// request. Set-all gives one result per channel for the first eight channels,
// every other request gives exactly one result.
// Channel state (setpoint, ramp mode, increment, remaining count) lives in one
// synchronous memory, the calibration bytes in a second one; each request is
// read, modified and written back through them.
// A request passes three steps: accept, memory read, then update and result.
// Set-all walks the channels one after another through the read and update
// steps, as every channel passes through the same read and write-back port.
// The result sits in an output register, so while it waits for i_m_tready the
// next request can be accepted and read; the update stalls until the register
// is free again.
// Reset clears the channel state at once through a valid bit per channel;
// the calibration memory is not cleared and has to be loaded before use.
module calibrated_dac_setpoint_ramp #(
    parameter int NUM_CHANNELS = cdsr_pkg::DEFAULT_NUM_CHANNELS,
    parameter int CAL_STEP     = cdsr_pkg::DEFAULT_CAL_STEP
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // func[2:0], channel[10:3], code[26:11], ramp_step[42:27],
    // ramp_count[58:43], cal_index[66:59], cal_value[74:67], zero fill above
    input  logic [cdsr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // status[1:0], setpoint_out[17:2], dac_write[18], dac_addr[24:19],
    // dac_code[40:25], zero fill above
    output logic [cdsr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CAL_DEPTH = NUM_CHANNELS * cdsr_pkg::CAL_ENTRIES;
    localparam int SHOWN     = (NUM_CHANNELS < cdsr_pkg::MAX_RESULTS) ?
                               NUM_CHANNELS : cdsr_pkg::MAX_RESULTS;
    localparam int CODE_W    = cdsr_pkg::CODE_W;
    localparam int PROD_W    = CODE_W + cdsr_pkg::RECIP_W;
    // Exact division of a 16-bit code by the step: multiply by the rounded-up
    // reciprocal and drop 16 + log2(step) bits.
    localparam int CAL_SHIFT = CODE_W + $clog2(CAL_STEP);
    localparam logic [cdsr_pkg::RECIP_W-1:0] CAL_RECIP =
        cdsr_pkg::RECIP_W'(((64'd1 << CAL_SHIFT) + 64'(CAL_STEP) - 64'd1) / 64'(CAL_STEP));
    localparam logic [CH_W:0]   SHOWN_C  = (CH_W + 1)'(SHOWN);
    localparam logic [CH_W-1:0] LAST_CH  = CH_W'(NUM_CHANNELS - 1);
    localparam logic [CH_W-1:0] LAST_OUT = CH_W'(SHOWN - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RD   = 3'b010,
        S_EX   = 3'b100
    } t_state;

    t_state r_state, n_state;

    cdsr_pkg::t_func               r_func;
    logic                          r_known;
    logic [CH_W-1:0]               r_ch;
    logic [CODE_W-1:0]             r_code;
    logic [CODE_W-1:0]             r_step;
    logic [CODE_W-1:0]             r_count;
    logic [cdsr_pkg::CAL_INDEX_W-1:0] r_cal_index;
    logic [7:0]                    r_cal_value;
    logic [cdsr_pkg::CAL_INDEX_W-1:0] r_cal_idx;

    cdsr_pkg::t_chan_state         r_st_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       r_st_vld;
    cdsr_pkg::t_chan_state         r_st_q;
    logic                          r_st_ok;
    logic [7:0]                    r_cal_mem [CAL_DEPTH];
    logic [7:0]                    r_cal_q;

    logic                          r_out_valid;
    logic [cdsr_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                          r_out_last;

    logic                          in_fire;
    logic [PROD_W-1:0]             quot_prod;
    logic [PROD_W-1:0]             quot;
    logic [CODE_W-1:0]             in_code;
    logic [7:0]                    in_channel;

    cdsr_pkg::t_chan_state         st;
    cdsr_pkg::t_chan_state         st_wd;
    logic [CODE_W:0]               cal_sum;
    logic [CODE_W-1:0]             cal_code;
    logic [CODE_W-1:0]             ramp_sp;
    cdsr_pkg::t_status             res_status;
    logic [CODE_W-1:0]             res_sp;
    logic                          res_wr;
    logic [cdsr_pkg::DAC_CH_W-1:0] res_ch;
    logic [CODE_W-1:0]             res_dc;
    logic                          res_emit;
    logic                          res_last;
    logic                          st_we;
    logic                          cal_we;
    logic                          more;
    logic                          out_free;
    logic                          proceed;

    assign in_fire    = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign in_code    = i_s_tdata[26:11];
    assign in_channel = i_s_tdata[10:3];
    assign quot_prod  = PROD_W'(in_code) * PROD_W'(CAL_RECIP);
    assign quot       = quot_prod >> CAL_SHIFT;

    assign out_free = !r_out_valid || i_m_tready;
    assign proceed  = (r_state == S_EX) && (out_free || !res_emit);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // Request capture; the calibration entry index is registered here.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func      <= cdsr_pkg::t_func'(i_s_tdata[2:0]);
            r_known     <= {1'b0, in_channel} < 9'(NUM_CHANNELS);
            r_code      <= in_code;
            r_step      <= i_s_tdata[42:27];
            r_count     <= i_s_tdata[58:43];
            r_cal_index <= i_s_tdata[66:59];
            r_cal_value <= i_s_tdata[74:67];
            r_cal_idx   <= (quot > PROD_W'(cdsr_pkg::CAL_ENTRIES - 1)) ?
                           8'hFF : quot[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (proceed) begin
                    n_state = more ? S_RD : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Channel pointer: the addressed channel, or a sweep over all for set-all.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch <= (cdsr_pkg::t_func'(i_s_tdata[2:0]) == cdsr_pkg::FUNC_SET_ALL) ?
                    '0 : in_channel[CH_W-1:0];
        end else if (proceed && more) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    // Channel state memory; an entry not written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (proceed && st_we) begin
            r_st_mem[r_ch] <= st_wd;
        end
        r_st_q <= r_st_mem[r_ch];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_vld <= '0;
            r_st_ok  <= 1'b0;
        end else begin
            if (proceed && st_we) begin
                r_st_vld[r_ch] <= 1'b1;
            end
            r_st_ok <= r_st_vld[r_ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && cal_we) begin
            r_cal_mem[{r_ch, r_cal_index}] <= r_cal_value;
        end
        r_cal_q <= r_cal_mem[{r_ch, r_cal_idx}];
    end

    always_comb begin
        st       = r_st_ok ? r_st_q : '0;
        cal_sum  = {1'b0, r_code} + (CODE_W + 1)'(r_cal_q);
        cal_code = cal_sum[CODE_W] ? cdsr_pkg::CODE_MAX : cal_sum[CODE_W-1:0];
        ramp_sp  = (st.remaining != '0) ? st.setpoint + st.increment : st.setpoint;

        res_status = cdsr_pkg::STATUS_OK;
        res_sp     = '0;
        res_wr     = 1'b0;
        res_ch     = '0;
        res_dc     = '0;
        res_emit   = 1'b1;
        res_last   = 1'b1;
        st_we      = 1'b0;
        st_wd      = st;
        cal_we     = 1'b0;
        more       = 1'b0;

        unique case (r_func)
            cdsr_pkg::FUNC_SET_ALL: begin
                st_we             = 1'b1;
                st_wd.setpoint    = r_code;
                st_wd.ramp_mode   = 1'b0;
                res_sp            = r_code;
                res_wr            = 1'b1;
                res_ch            = cdsr_pkg::DAC_CH_W'(r_ch);
                res_dc            = cal_code;
                res_emit          = {1'b0, r_ch} < SHOWN_C;
                res_last          = (r_ch == LAST_OUT);
                more              = (r_ch != LAST_CH);
            end
            cdsr_pkg::FUNC_SET, cdsr_pkg::FUNC_GET, cdsr_pkg::FUNC_RAMP_START,
            cdsr_pkg::FUNC_RAMP_NEXT, cdsr_pkg::FUNC_CAL_LOAD: begin
                if (!r_known) begin
                    res_status = cdsr_pkg::STATUS_UNKNOWN;
                end else begin
                    res_sp = st.setpoint;
                    unique case (r_func)
                        cdsr_pkg::FUNC_SET: begin
                            st_we           = 1'b1;
                            st_wd.setpoint  = r_code;
                            st_wd.ramp_mode = 1'b0;
                            res_sp          = r_code;
                            res_wr          = 1'b1;
                            res_ch          = cdsr_pkg::DAC_CH_W'(r_ch);
                            res_dc          = cal_code;
                        end
                        cdsr_pkg::FUNC_RAMP_START: begin
                            st_we           = 1'b1;
                            st_wd.setpoint  = r_code;
                            st_wd.increment = r_step;
                            st_wd.remaining = r_count;
                            st_wd.ramp_mode = 1'b1;
                            res_sp          = r_code;
                            res_wr          = 1'b1;
                            res_ch          = cdsr_pkg::DAC_CH_W'(r_ch);
                            res_dc          = r_code;
                        end
                        cdsr_pkg::FUNC_RAMP_NEXT: begin
                            if (!st.ramp_mode) begin
                                res_status = cdsr_pkg::STATUS_NOT_RAMPING;
                            end else begin
                                // A used-up count repeats the current setpoint.
                                st_we          = 1'b1;
                                st_wd.setpoint = ramp_sp;
                                if (st.remaining != '0) begin
                                    st_wd.remaining = st.remaining - 1'b1;
                                end
                                res_sp = ramp_sp;
                                res_wr = 1'b1;
                                res_ch = cdsr_pkg::DAC_CH_W'(r_ch);
                                res_dc = ramp_sp;
                            end
                        end
                        cdsr_pkg::FUNC_CAL_LOAD: begin
                            cal_we = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && res_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && res_emit) begin
            r_out_data <= {7'b0, res_dc, res_ch, res_wr, res_sp, res_status};
            r_out_last <= res_last;
        end
    end

endmodule
